// ===== hdl/fmrws_pkg.sv =====
// Package with shared constants, types and single-precision arithmetic functions.
package fmrws_pkg;

  localparam int unsigned MAX_HEADS  = 64;
  localparam int unsigned VEC_LEN    = 128;
  localparam int unsigned CHUNKS     = VEC_LEN / 8;
  localparam int unsigned HEAD_W     = $clog2(MAX_HEADS);
  localparam int unsigned CHUNK_W    = $clog2(CHUNKS);
  localparam int unsigned HCNT_W     = $clog2(MAX_HEADS + 1);
  localparam int unsigned QADDR_W    = HEAD_W + CHUNK_W;
  localparam int unsigned NH_RESET   = 64;
  localparam logic [31:0] CANON_NAN  = 32'h7FC0_0000;
  localparam logic [31:0] POS_ZERO   = 32'h0000_0000;

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_WEIGHT = 2'd1,
    OP_KEY    = 2'd2,
    OP_NONE   = 2'd3
  } fmrws_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD,
    ST_LOAD,
    ST_MAC,
    ST_WR,
    ST_FIN_START,
    ST_FHEAD,
    ST_FLOAD,
    ST_FADD,
    ST_SCALE
  } fmrws_state_e;

  typedef struct packed {
    logic              load_q;
    logic              load_w;
    logic              latch_key;
    logic              clr_valid;
    logic              rd;
    logic              acc_load;
    logic              mul_elem;
    logic              add_acc;
    logic              wr_dot;
    logic              sum_clr;
    logic              mul_fin;
    logic              add_sum;
    logic              mul_scale;
    logic [HEAD_W-1:0] head;
    logic [2:0]        elem;
  } fmrws_cmd_t;

  typedef struct packed {
    logic out_full;
  } fmrws_status_t;

  // Rounds a significand with its leading one at bit 26 (three extra low bits) and packs it.
  function automatic logic [31:0] fp_round_pack(input logic s, input logic signed [11:0] ex,
                                                input logic [26:0] m);
    logic signed [11:0] d;
    logic [5:0]         shc;
    logic [53:0]        t;
    logic [26:0]        mm;
    logic signed [11:0] exn;
    logic               inc;
    logic [24:0]        rnd;
    logic signed [11:0] ef;
    logic [22:0]        frac;
    mm  = m;
    exn = ex;
    d   = 12'sd1 - ex;
    shc = 6'd0;
    t   = '0;
    if (ex < 12'sd1) begin
      shc = (d > 12'sd28) ? 6'd28 : d[5:0];
      t   = {m, 27'b0} >> shc;
      mm  = {t[53:28], t[27] | (|t[26:0])};
      exn = 12'sd1;
    end
    inc = mm[2] & (mm[3] | mm[1] | mm[0]);
    rnd = {1'b0, mm[26:3]} + {24'b0, inc};
    if (rnd[24]) begin
      ef   = exn + 12'sd1;
      frac = '0;
    end else begin
      ef   = rnd[23] ? exn : 12'sd0;
      frac = rnd[22:0];
    end
    if (ef >= 12'sd255) return {s, 8'hFF, 23'b0};
    return {s, ef[7:0], frac};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic               s;
    logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0]        ma, mb;
    logic [7:0]         ea, eb;
    logic [47:0]        p;
    logic [47:0]        pr;
    logic [47:0]        mask;
    logic [5:0]         k;
    logic [5:0]         sh;
    logic [26:0]        m27;
    logic signed [11:0] ex;
    s      = a[31] ^ b[31];
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    a_zero = (a[30:0] == '0);
    b_zero = (b[30:0] == '0);
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) return CANON_NAN;
    if (a_inf || b_inf) return {s, 8'hFF, 23'b0};
    if (a_zero || b_zero) return {s, 31'b0};
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    p  = ma * mb;
    k  = '0;
    for (int i = 0; i < 48; i++) begin
      if (p[i]) k = 6'(i);
    end
    ex = $signed({4'b0, ea}) + $signed({4'b0, eb}) + $signed({6'b0, k}) - 12'sd173;
    if (k >= 6'd26) begin
      sh   = k - 6'd26;
      pr   = p >> sh;
      mask = (48'd1 << sh) - 48'd1;
      m27  = pr[26:0] | {26'b0, |(p & mask)};
    end else begin
      sh  = 6'd26 - k;
      pr  = p << sh;
      m27 = pr[26:0];
    end
    return fp_round_pack(s, ex, m27);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic               a_nan, b_nan, a_inf, b_inf;
    logic [31:0]        x, y;
    logic [7:0]         e1, e2;
    logic [7:0]         dd;
    logic [5:0]         shc;
    logic [26:0]        m1, m2;
    logic [53:0]        t;
    logic [26:0]        m2s;
    logic [27:0]        r;
    logic [27:0]        rl;
    logic [4:0]         k;
    logic [26:0]        m27;
    logic signed [11:0] ex;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) return CANON_NAN;
    if (a_inf) return a;
    if (b_inf) return b;
    if ((a[30:0] == '0) && (b[30:0] == '0)) return {a[31] & b[31], 31'b0};
    if (a[30:0] < b[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    e1  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    e2  = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    m1  = {x[30:23] != 8'd0, x[22:0], 3'b0};
    m2  = {y[30:23] != 8'd0, y[22:0], 3'b0};
    dd  = e1 - e2;
    shc = (dd > 8'd28) ? 6'd28 : dd[5:0];
    t   = {m2, 27'b0} >> shc;
    m2s = {t[53:28], t[27] | (|t[26:0])};
    if (x[31] == y[31]) r = {1'b0, m1} + {1'b0, m2s};
    else                r = {1'b0, m1} - {1'b0, m2s};
    if (r == '0) return POS_ZERO;
    k = '0;
    for (int i = 0; i < 28; i++) begin
      if (r[i]) k = 5'(i);
    end
    ex = $signed({4'b0, e1}) + $signed({7'b0, k}) - 12'sd26;
    if (k == 5'd27) begin
      m27 = {r[27:2], r[1] | r[0]};
    end else begin
      rl  = r << (5'd26 - k);
      m27 = rl[26:0];
    end
    return fp_round_pack(x[31], ex, m27);
  endfunction

  // Exact widening of an e4m3fn byte to single precision.
  function automatic logic [31:0] fp8_to_fp32(input logic [7:0] v);
    logic        s;
    logic [3:0]  e;
    logic [2:0]  m;
    logic [7:0]  eb;
    s  = v[7];
    e  = v[6:3];
    m  = v[2:0];
    eb = {4'b0, e} + 8'd120;
    if ((e == 4'hF) && (m == 3'h7)) return CANON_NAN;
    if (e != 4'd0) return {s, eb, m, 20'b0};
    if (m == 3'd0) return {s, 31'b0};
    if (m[2])      return {s, 8'd120, m[1:0], 21'b0};
    if (m[1])      return {s, 8'd119, m[0], 22'b0};
    return {s, 8'd118, 23'b0};
  endfunction

endpackage

// ===== hdl/fmrws_if.sv =====
// Handshake channel interfaces for key items, score items and configuration writes.
interface fmrws_key_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [5:0]  head;
  logic [3:0]  chunk;
  logic [63:0] packed_bytes;
  logic [31:0] weight_bits;
  logic [31:0] key_scale;
  modport source (output valid, opcode, head, chunk, packed_bytes, weight_bits, key_scale,
                  input ready);
  modport sink (input valid, opcode, head, chunk, packed_bytes, weight_bits, key_scale,
                output ready);
endinterface

interface fmrws_score_if;
  logic        valid;
  logic        ready;
  logic [31:0] logit;
  modport source (output valid, logit, input ready);
  modport sink (input valid, logit, output ready);
endinterface

interface fmrws_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] active_heads;
  modport source (output valid, active_heads, input ready);
  modport sink (input valid, active_heads, output ready);
endinterface

// ===== hdl/fmrws_datapath.sv =====
// Datapath: query, weight and partial-dot stores, the MAC unit and the result register.
module fmrws_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fmrws_pkg::fmrws_cmd_t cmd_i,
  input  logic [5:0]            head_i,
  input  logic [3:0]            chunk_i,
  input  logic [63:0]           packed_bytes_i,
  input  logic [31:0]           weight_bits_i,
  input  logic [31:0]           key_scale_i,
  output fmrws_pkg::fmrws_status_t status_o,
  fmrws_score_if.source          score
);
  import fmrws_pkg::*;

  logic [63:0] qmem [MAX_HEADS*CHUNKS];
  logic [31:0] wmem [MAX_HEADS];
  logic [31:0] dmem [MAX_HEADS];
  logic [MAX_HEADS-1:0] dvalid_q;

  logic [63:0]        key_q;
  logic [31:0]        scale_q;
  logic [CHUNK_W-1:0] chunk_q;
  logic [63:0]        q_rd_q;
  logic [31:0]        w_rd_q;
  logic [31:0]        d_rd_q;
  logic               dv_rd_q;
  logic [31:0]        acc_q;
  logic [31:0]        prod_q;
  logic [31:0]        sum_q;
  logic [31:0]        res_q;
  logic               out_valid_q;
  logic [31:0]        dot;
  logic [31:0]        relu_dot;
  logic [31:0]        scaled;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_q) qmem[{head_i[HEAD_W-1:0], chunk_i[CHUNK_W-1:0]}] <= packed_bytes_i;
    if (cmd_i.load_w) wmem[head_i[HEAD_W-1:0]] <= weight_bits_i;
    if (cmd_i.wr_dot) dmem[cmd_i.head] <= acc_q;
    if (cmd_i.rd) begin
      q_rd_q <= qmem[{cmd_i.head, chunk_q}];
      w_rd_q <= wmem[cmd_i.head];
      d_rd_q <= dmem[cmd_i.head];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvalid_q    <= '0;
      dv_rd_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_valid) dvalid_q <= '0;
      else if (cmd_i.wr_dot) dvalid_q[cmd_i.head] <= 1'b1;
      if (cmd_i.rd) dv_rd_q <= dvalid_q[cmd_i.head];
      if (cmd_i.mul_scale) out_valid_q <= 1'b1;
      else if (score.ready) out_valid_q <= 1'b0;
    end
  end

  // A partial dot never written since the last first chunk reads as zero.
  assign dot      = dv_rd_q ? d_rd_q : POS_ZERO;
  assign relu_dot = (dot[31] && !((dot[30:23] == 8'hFF) && (dot[22:0] != '0)) &&
                     (dot[30:0] != '0)) ? POS_ZERO : dot;
  assign scaled   = fp_mul(sum_q, scale_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_key) begin
      key_q   <= packed_bytes_i;
      scale_q <= key_scale_i;
      chunk_q <= chunk_i[CHUNK_W-1:0];
    end
    if (cmd_i.acc_load) acc_q <= (chunk_q == '0) ? POS_ZERO : dot;
    else if (cmd_i.add_acc) acc_q <= fp_add(acc_q, prod_q);
    if (cmd_i.mul_elem) begin
      prod_q <= fp_mul(fp8_to_fp32(key_q[8*cmd_i.elem +: 8]),
                       fp8_to_fp32(q_rd_q[8*cmd_i.elem +: 8]));
    end else if (cmd_i.mul_fin) begin
      prod_q <= fp_mul(relu_dot, w_rd_q);
    end
    if (cmd_i.sum_clr) sum_q <= POS_ZERO;
    else if (cmd_i.add_sum) sum_q <= fp_add(sum_q, prod_q);
    if (cmd_i.mul_scale) res_q <= scaled;
  end

  assign score.valid       = out_valid_q;
  assign score.logit       = res_q;
  assign status_o.out_full = out_valid_q;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul_scale |-> !out_valid_q)
    else $error("result overwritten while still pending");
  a_result_nan_canon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q[30:23] == 8'hFF) && (res_q[22:0] != '0)) |-> (res_q == CANON_NAN))
    else $error("NaN result not canonical");
  a_mac_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.mul_elem && cmd_i.mul_fin) && !(cmd_i.acc_load && cmd_i.add_acc))
    else $error("conflicting datapath commands");
`endif

endmodule

// ===== hdl/fmrws_ctrl.sv =====
// Controller state machine sequencing loads, per-head MACs and the final weighted sum.
module fmrws_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                opcode_i,
  input  logic [3:0]                chunk_i,
  input  logic [5:0]                head_i,
  input  logic [6:0]                active_heads_i,
  input  fmrws_pkg::fmrws_status_t  status_i,
  output fmrws_pkg::fmrws_cmd_t     cmd_o
);
  import fmrws_pkg::*;

  fmrws_state_e      state_q, state_d;
  logic [HCNT_W-1:0] h_q, h_d;
  logic [HCNT_W-1:0] nh_q, nh_d;
  logic [3:0]        e_q, e_d;
  logic              last_q, last_d;
  logic              accept;
  logic              chunk_ok;
  logic              head_ok;

  assign accept   = in_valid_i && in_ready_o;
  assign chunk_ok = {1'b0, chunk_i} < 5'(CHUNKS);
  assign head_ok  = {1'b0, head_i} < 7'(MAX_HEADS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      h_q     <= '0;
      nh_q    <= '0;
      e_q     <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      h_q     <= h_d;
      nh_q    <= nh_d;
      e_q     <= e_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    h_d        = h_q;
    nh_d       = nh_q;
    e_d        = e_q;
    last_d     = last_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.head = h_q[HEAD_W-1:0];
    cmd_o.elem = e_q[2:0];
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept && chunk_ok) begin
          priority if (opcode_i == OP_QUERY) begin
            cmd_o.load_q = head_ok;
          end else if (opcode_i == OP_WEIGHT) begin
            cmd_o.load_w = head_ok;
          end else if (opcode_i == OP_KEY) begin
            cmd_o.latch_key = 1'b1;
            cmd_o.clr_valid = (chunk_i == '0);
            h_d     = '0;
            nh_d    = (active_heads_i > 7'(MAX_HEADS)) ? HCNT_W'(MAX_HEADS)
                                                       : HCNT_W'(active_heads_i);
            last_d  = ({1'b0, chunk_i} == 5'(CHUNKS - 1));
            state_d = ST_HEAD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_HEAD: begin
        if (h_q == nh_q) begin
          state_d = last_q ? ST_FIN_START : ST_IDLE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.acc_load = 1'b1;
        e_d            = '0;
        state_d        = ST_MAC;
      end
      ST_MAC: begin
        // The product of one element is added in the cycle after it is formed.
        cmd_o.mul_elem = (e_q != 4'd8);
        cmd_o.add_acc  = (e_q != 4'd0);
        if (e_q == 4'd8) state_d = ST_WR;
        else e_d = e_q + 4'd1;
      end
      ST_WR: begin
        cmd_o.wr_dot = 1'b1;
        h_d          = h_q + 1'b1;
        state_d      = ST_HEAD;
      end
      ST_FIN_START: begin
        cmd_o.sum_clr = 1'b1;
        h_d           = '0;
        state_d       = ST_FHEAD;
      end
      ST_FHEAD: begin
        if (h_q == nh_q) begin
          state_d = ST_SCALE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = ST_FLOAD;
        end
      end
      ST_FLOAD: begin
        cmd_o.mul_fin = 1'b1;
        state_d       = ST_FADD;
      end
      ST_FADD: begin
        cmd_o.add_sum = 1'b1;
        h_d           = h_q + 1'b1;
        state_d       = ST_FHEAD;
      end
      ST_SCALE: begin
        if (!status_i.out_full) begin
          cmd_o.mul_scale = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (h_q <= nh_q))
    else $error("head counter ran past head count");
  a_elem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> (e_q <= 4'd8))
    else $error("element counter out of range");
  a_nh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nh_q <= HCNT_W'(MAX_HEADS))
    else $error("head count not saturated");
  a_scale_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul_scale |-> last_q)
    else $error("score produced for a chunk that is not the last");
`endif

endmodule

// ===== hdl/fp8_multihead_relu_weighted_score.sv =====
// Top level: multi-head FP8 query/key scorer with ReLU and per-head weighting.
// Load items (query chunk, head weight) are written into their stores when accepted.
// A key chunk is processed head by head for the heads in use on one serial float MAC unit:
// per head a read, an accumulator load, eight element MACs and a write-back.
// After the last chunk the weighted sum over the heads is formed and scaled, and the score appears.
// Reset clears control state and sets the head count to 64; stores are undefined until loaded.
module fp8_multihead_relu_weighted_score (
  input  logic          clk_i,
  input  logic          rst_ni,
  fmrws_cfg_if.sink     cfg_i,
  fmrws_key_if.sink     key_i,
  fmrws_score_if.source score_o
);
  import fmrws_pkg::*;

  logic [6:0]    active_heads_q;
  fmrws_cmd_t    cmd;
  fmrws_status_t status;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_heads_q <= 7'(NH_RESET);
    end else if (cfg_i.valid) begin
      active_heads_q <= cfg_i.active_heads;
    end
  end

  fmrws_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (key_i.valid),
    .in_ready_o     (key_i.ready),
    .opcode_i       (key_i.opcode),
    .chunk_i        (key_i.chunk),
    .head_i         (key_i.head),
    .active_heads_i (active_heads_q),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  fmrws_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .head_i         (key_i.head),
    .chunk_i        (key_i.chunk),
    .packed_bytes_i (key_i.packed_bytes),
    .weight_bits_i  (key_i.weight_bits),
    .key_scale_i    (key_i.key_scale),
    .status_o       (status),
    .score          (score_o)
  );

endmodule
